@@ sv/diff_drive_wheel_arm_pid_assert.svh @@
// Assertion macros shared by the control block and its lanes.
// Both expect clk and rst_n in scope.
`ifndef DIFF_DRIVE_WHEEL_ARM_PID_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_ARM_PID_ASSERT_SVH

// same-cycle implication
`define DDWAP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddwap assertion failed");

// next-cycle implication
`define DDWAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddwap assertion failed");

`endif

@@ sv/ddwap_pkg.sv @@
package ddwap_pkg;

  localparam int NUM_REGS = 7;

  typedef logic [31:0] word_t;

  // register indexes
  localparam logic [2:0] REG_INV_RADIUS = 3'd0;
  localparam logic [2:0] REG_YAW_SCALE  = 3'd1;
  localparam logic [2:0] REG_WHEEL_KP   = 3'd2;
  localparam logic [2:0] REG_WHEEL_KI   = 3'd3;
  localparam logic [2:0] REG_ARM_KP     = 3'd4;
  localparam logic [2:0] REG_ARM_KI     = 3'd5;
  localparam logic [2:0] REG_ARM_KD     = 3'd6;

  localparam word_t CFG_RESET [NUM_REGS] = '{
    32'd862315, 32'd125036, 32'd32768, 32'd7, 32'd6553600, 32'd0, 32'd0
  };

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  // kinematics result handed to the wheel lanes
  typedef struct packed {
    logic               done;
    logic               clear;
    logic signed [31:0] err_left;
    logic signed [31:0] err_right;
  } kin_res_t;

  // per-lane start request
  typedef struct packed {
    logic               start;
    logic               clear;
    logic signed [31:0] err;
    logic signed [16:0] drv;
  } lane_req_t;

  // per-lane gains, unsigned Q16.16
  typedef struct packed {
    word_t kp;
    word_t ki;
    word_t kd;
  } lane_gain_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/ddwap_kin.sv @@
// Differential-drive kinematics: wheel targets, wheel errors, zero test.
module ddwap_kin import ddwap_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic signed [15:0] fwd_i,
  input  logic signed [15:0] yaw_i,
  input  logic signed [15:0] spd_left_i,
  input  logic signed [15:0] spd_right_i,
  input  word_t              inv_radius_i,
  input  word_t              yaw_scale_i,
  output kin_res_t           res_o
);

  logic               busy_r;
  logic [1:0]         step_r;
  logic               done_r;
  logic               clear_r;
  logic signed [31:0] err_left_r;
  logic signed [31:0] err_right_r;
  logic signed [48:0] prod_r;
  logic signed [32:0] x_r;
  logic signed [33:0] tl_r;
  logic signed [33:0] tr_r;

  logic signed [15:0] mul_a;
  logic signed [32:0] mul_g;
  logic signed [48:0] mul_p;
  logic signed [32:0] y_val;
  logic signed [63:0] diff_left;
  logic signed [63:0] diff_right;

  // shared multiplier: forward speed first, then yaw rate
  always_comb begin
    if (!busy_r) begin
      mul_a = fwd_i;
      mul_g = $signed({1'b0, inv_radius_i});
    end else begin
      mul_a = yaw_i;
      mul_g = $signed({1'b0, yaw_scale_i});
    end
  end

  assign mul_p = mul_a * mul_g;
  assign y_val = $signed(prod_r[48:16]);

  assign diff_left  = {{30{tl_r[33]}}, tl_r} - {{48{spd_left_i[15]}}, spd_left_i};
  assign diff_right = {{30{tr_r[33]}}, tr_r} - {{48{spd_right_i[15]}}, spd_right_i};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start_i) begin
          busy_r <= 1'b1;
          step_r <= 2'd1;
        end
      end else begin
        case (step_r)
          2'd1: step_r <= 2'd2;
          2'd2: step_r <= 2'd3;
          default: begin
            step_r <= 2'd0;
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (start_i) begin
        prod_r <= mul_p;
      end
    end else begin
      case (step_r)
        2'd1: begin
          x_r    <= $signed(prod_r[48:16]);
          prod_r <= mul_p;
        end
        2'd2: begin
          tl_r <= {x_r[32], x_r} - {y_val[32], y_val};
          tr_r <= {x_r[32], x_r} + {y_val[32], y_val};
        end
        default: begin
          err_left_r  <= sat32(diff_left);
          err_right_r <= sat32(diff_right);
          clear_r     <= (tl_r == 34'sd0) && (tr_r == 34'sd0);
        end
      endcase
    end
  end

  assign res_o = '{done: done_r, clear: clear_r,
                   err_left: err_left_r, err_right: err_right_r};

endmodule

@@ sv/ddwap_lane.sv @@
// One control lane: P, I and D terms through one multiplier, then the
// integrator update.
module ddwap_lane import ddwap_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_req_t          req_i,
  input  lane_gain_t         gain_i,
  output logic               done_o,
  output logic signed [31:0] torque_o
);

`include "diff_drive_wheel_arm_pid_assert.svh"

  logic               busy_r;
  logic [1:0]         step_r;
  logic               done_r;
  logic signed [31:0] sum_r;
  logic signed [31:0] err_r;
  logic signed [16:0] drv_r;
  logic signed [64:0] prod_r;
  logic signed [49:0] acc_r;
  logic signed [31:0] torque_r;

  logic signed [31:0] mul_a;
  word_t              mul_g;
  logic signed [64:0] mul_p;
  logic signed [49:0] term;
  logic signed [49:0] fin;
  logic signed [31:0] sum_new;

  // operand select: error on start, then sum, then derivative operand
  always_comb begin
    if (!busy_r) begin
      mul_a = req_i.err;
      mul_g = gain_i.kp;
    end else begin
      case (step_r)
        2'd1: begin
          mul_a = sum_r;
          mul_g = gain_i.ki;
        end
        2'd2: begin
          mul_a = {{15{drv_r[16]}}, drv_r};
          mul_g = gain_i.kd;
        end
        default: begin
          mul_a = err_r;
          mul_g = gain_i.kp;
        end
      endcase
    end
  end

  assign mul_p = mul_a * $signed({1'b0, mul_g});

  // floor shift of the registered product
  assign term = {prod_r[64], prod_r[64:16]};
  assign fin  = acc_r + term;
  assign sum_new = sat32({{32{sum_r[31]}}, sum_r} + {{32{err_r[31]}}, err_r});

  // control and integrator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req_i.start) begin
          busy_r <= 1'b1;
          step_r <= 2'd1;
          if (req_i.clear) begin
            sum_r <= '0;
          end
        end
      end else begin
        case (step_r)
          2'd1: step_r <= 2'd2;
          2'd2: step_r <= 2'd3;
          default: begin
            step_r <= 2'd0;
            busy_r <= 1'b0;
            done_r <= 1'b1;
            sum_r  <= sum_new;
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (req_i.start) begin
        err_r  <= req_i.err;
        drv_r  <= req_i.drv;
        prod_r <= mul_p;
      end
    end else begin
      case (step_r)
        2'd1: begin
          prod_r <= mul_p;
          acc_r  <= term;
        end
        2'd2: begin
          prod_r <= mul_p;
          acc_r  <= fin;
        end
        default: begin
          torque_r <= sat32({{14{fin[49]}}, fin});
        end
      endcase
    end
  end

  assign done_o   = done_r;
  assign torque_o = torque_r;

  `DDWAP_ASSERT_IMPL(a_start_idle, req_i.start, !busy_r)
  `DDWAP_ASSERT_NEXT(a_done_pulse, done_r, !done_r && !busy_r)
  `DDWAP_ASSERT_IMPL(a_step_busy, busy_r, step_r != 2'd0)

endmodule

@@ sv/diff_drive_wheel_arm_pid.sv @@
// Channel | Dir | Handshake               | Payload
// in_     | in  | in_tvalid / in_tready   | 8 x 16-bit signed Q8.8 commands and measurements
// out_    | out | out_tvalid / out_tready | 4 x 32-bit signed Q24.8 torques
// cfg_    | in  | APB, pready tied high   | 7 x 32-bit Q16.16 registers at 4*i
//
// While out_tready is high, an item passes from acceptance through the start register, the
// kinematics unit (one multiplier used for both commands), the lanes (one multiplier per lane,
// three gain terms) and the output register; the next item is accepted only after that.
// A stalled result waits in the output register while the next item is taken; a result that
// finishes before the register is free waits in the lanes, and no new item is taken meanwhile.
// Synchronous active-low reset restores register defaults and clears all integrators.
module diff_drive_wheel_arm_pid import ddwap_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // forward_speed_cmd, yaw_rate_cmd, arm_one_target, arm_two_target,
  // left_wheel_speed, right_wheel_speed, arm_one_angle, arm_two_angle
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_wheel_torque, right_wheel_torque, arm_one_torque, arm_two_torque
  output logic [127:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

`include "diff_drive_wheel_arm_pid_assert.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_KIN, ST_LANE, ST_HOLD} state_t;

  state_t             state_r;
  logic               kin_start_r;
  logic               out_valid_r;
  logic [127:0]       out_data_r;
  word_t              cfg_r [NUM_REGS];
  logic signed [15:0] prev_r [2];

  logic signed [15:0] fwd_r, yaw_r, tgt1_r, tgt2_r, spdl_r, spdr_r, ang1_r, ang2_r;

  logic               in_fire;
  logic               out_free;
  logic [2:0]         cfg_idx;
  logic               cfg_wr;
  kin_res_t           kin_res;
  lane_req_t          lane_req [4];
  lane_gain_t         lane_gain [4];
  logic [3:0]         lane_done;
  logic signed [31:0] lane_torque [4];
  logic [127:0]       result;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_wr && (cfg_idx < 3'(NUM_REGS))) begin
      cfg_r[cfg_idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    if (cfg_idx < 3'(NUM_REGS)) begin
      cfg_prdata = cfg_r[cfg_idx];
    end else begin
      cfg_prdata = '0;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_r  <= $signed(in_tdata[15:0]);
      yaw_r  <= $signed(in_tdata[31:16]);
      tgt1_r <= $signed(in_tdata[47:32]);
      tgt2_r <= $signed(in_tdata[63:48]);
      spdl_r <= $signed(in_tdata[79:64]);
      spdr_r <= $signed(in_tdata[95:80]);
      ang1_r <= $signed(in_tdata[111:96]);
      ang2_r <= $signed(in_tdata[127:112]);
    end
  end

  // previous arm angle, stored after its use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r[0] <= '0;
      prev_r[1] <= '0;
    end else if (kin_res.done) begin
      prev_r[0] <= ang1_r;
      prev_r[1] <= ang2_r;
    end
  end

  ddwap_kin u_kin (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (kin_start_r),
    .fwd_i        (fwd_r),
    .yaw_i        (yaw_r),
    .spd_left_i   (spdl_r),
    .spd_right_i  (spdr_r),
    .inv_radius_i (cfg_r[REG_INV_RADIUS]),
    .yaw_scale_i  (cfg_r[REG_YAW_SCALE]),
    .res_o        (kin_res)
  );

  // lane requests: two wheel lanes, two arm lanes
  always_comb begin
    lane_req[0] = '{start: kin_res.done, clear: kin_res.clear,
                    err: kin_res.err_left, drv: 17'sd0};
    lane_req[1] = '{start: kin_res.done, clear: kin_res.clear,
                    err: kin_res.err_right, drv: 17'sd0};
    lane_req[2] = '{start: kin_res.done, clear: 1'b0,
                    err: {{16{tgt1_r[15]}}, tgt1_r} - {{16{ang1_r[15]}}, ang1_r},
                    drv: {prev_r[0][15], prev_r[0]} - {ang1_r[15], ang1_r}};
    lane_req[3] = '{start: kin_res.done, clear: 1'b0,
                    err: {{16{tgt2_r[15]}}, tgt2_r} - {{16{ang2_r[15]}}, ang2_r},
                    drv: {prev_r[1][15], prev_r[1]} - {ang2_r[15], ang2_r}};
    lane_gain[0] = '{kp: cfg_r[REG_WHEEL_KP], ki: cfg_r[REG_WHEEL_KI], kd: 32'd0};
    lane_gain[1] = lane_gain[0];
    lane_gain[2] = '{kp: cfg_r[REG_ARM_KP], ki: cfg_r[REG_ARM_KI], kd: cfg_r[REG_ARM_KD]};
    lane_gain[3] = lane_gain[2];
  end

  // four lanes: arm error is sign-extended to 32 bits above
  for (genvar g = 0; g < 4; g++) begin : g_lane
    ddwap_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .req_i    (lane_req[g]),
      .gain_i   (lane_gain[g]),
      .done_o   (lane_done[g]),
      .torque_o (lane_torque[g])
    );
  end

  // merge lane torques into one result transaction
  assign result = {lane_torque[3], lane_torque[2], lane_torque[1], lane_torque[0]};

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kin_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      kin_start_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r     <= ST_KIN;
            kin_start_r <= 1'b1;
          end
        end
        ST_KIN: begin
          if (kin_res.done) begin
            state_r <= ST_LANE;
          end
        end
        ST_LANE: begin
          if (&lane_done) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_data_r  <= result;
              state_r     <= ST_IDLE;
            end else begin
              state_r <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= result;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `DDWAP_ASSERT_NEXT(a_accept_busy, in_fire, !in_tready)
  `DDWAP_ASSERT_IMPL(a_lanes_lockstep, |lane_done, (&lane_done) && (state_r == ST_LANE))
  `DDWAP_ASSERT_IMPL(a_kin_done_state, kin_res.done, state_r == ST_KIN)
  `DDWAP_ASSERT_IMPL(a_out_rise, $rose(out_valid_r), $past(state_r == ST_LANE || state_r == ST_HOLD))

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ddwap_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // fields listed high to low so the packed struct lines up with tdata
  typedef struct packed {
    logic signed [15:0] arm_two_angle;
    logic signed [15:0] arm_one_angle;
    logic signed [15:0] right_wheel_speed;
    logic signed [15:0] left_wheel_speed;
    logic signed [15:0] arm_two_target;
    logic signed [15:0] arm_one_target;
    logic signed [15:0] yaw_rate_cmd;
    logic signed [15:0] forward_speed_cmd;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] arm_two_torque;
    logic signed [31:0] arm_one_torque;
    logic signed [31:0] right_wheel_torque;
    logic signed [31:0] left_wheel_torque;
  } torques_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // controller image: gains, integrators, last arm angles
  word_t              gain_reg   [NUM_REGS];
  logic signed [31:0] wheel_sum  [2];
  logic signed [31:0] arm_sum    [2];
  logic signed [15:0] prev_angle [2];

  torques_t torque_fifo [$];
  string    torque_name [4] = '{"left_wheel_torque", "right_wheel_torque",
                                "arm_one_torque", "arm_two_torque"};

  int mismatch_count = 0;
  int result_count   = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_left   = 0;

  diff_drive_wheel_arm_pid uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // signed operand times unsigned Q16.16 gain, floored back by 16 bits
  function automatic longint scale_gain(input longint v, input word_t g);
    longint gg;
    gg = {32'b0, g};
    return (v * gg) >>> 16;
  endfunction

  task automatic predict_tick(input tick_t t);
    longint   x, y, err, aerr, adrv, trq;
    longint   wheel_tgt [2];
    longint   wheel_spd [2];
    longint   arm_tgt   [2];
    longint   arm_ang   [2];
    longint   wheel_trq [2];
    longint   arm_trq   [2];
    torques_t want;
    int       i;
    wheel_spd[0] = $signed(t.left_wheel_speed);
    wheel_spd[1] = $signed(t.right_wheel_speed);
    arm_tgt[0]   = $signed(t.arm_one_target);
    arm_tgt[1]   = $signed(t.arm_two_target);
    arm_ang[0]   = $signed(t.arm_one_angle);
    arm_ang[1]   = $signed(t.arm_two_angle);

    // differential-drive kinematics
    x = scale_gain($signed(t.forward_speed_cmd), gain_reg[REG_INV_RADIUS]);
    y = scale_gain($signed(t.yaw_rate_cmd), gain_reg[REG_YAW_SCALE]);
    wheel_tgt[0] = x - y;
    wheel_tgt[1] = x + y;

    // both targets zero: wheel integrators dumped before use
    if (wheel_tgt[0] == 0 && wheel_tgt[1] == 0) begin
      wheel_sum[0] = '0;
      wheel_sum[1] = '0;
    end

    for (i = 0; i < 2; i++) begin
      // wheel PI, integral from the sum before this tick
      err = clamp_s32(wheel_tgt[i] - wheel_spd[i]);
      trq = scale_gain(err, gain_reg[REG_WHEEL_KP])
          + scale_gain($signed(wheel_sum[i]), gain_reg[REG_WHEEL_KI]);
      wheel_trq[i] = clamp_s32(trq);
      wheel_sum[i] = 32'(clamp_s32($signed(wheel_sum[i]) + err));

      // arm PID, derivative on previous minus current angle
      aerr = arm_tgt[i] - arm_ang[i];
      adrv = $signed(prev_angle[i]) - arm_ang[i];
      trq = scale_gain(aerr, gain_reg[REG_ARM_KP])
          + scale_gain($signed(arm_sum[i]), gain_reg[REG_ARM_KI])
          + scale_gain(adrv, gain_reg[REG_ARM_KD]);
      arm_trq[i] = clamp_s32(trq);
      arm_sum[i] = 32'(clamp_s32($signed(arm_sum[i]) + aerr));
      prev_angle[i] = 16'(arm_ang[i]);
    end

    want.left_wheel_torque  = 32'(wheel_trq[0]);
    want.right_wheel_torque = 32'(wheel_trq[1]);
    want.arm_one_torque     = 32'(arm_trq[0]);
    want.arm_two_torque     = 32'(arm_trq[1]);
    torque_fifo.push_back(want);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
             what, got, want, result_count);
  endtask

  always @(posedge clk) begin : result_check
    logic [127:0] want_bits;
    int k;
    if (rst_n && out_tvalid && out_tready) begin
      if (torque_fifo.size() == 0) begin
        report_mismatch("result with no pending tick", 0, 0);
      end else begin
        want_bits = torque_fifo.pop_front();
        for (k = 0; k < 4; k++)
          if (out_tdata[32*k +: 32] !== want_bits[32*k +: 32])
            report_mismatch(torque_name[k], $signed(out_tdata[32*k +: 32]),
                            $signed(want_bits[32*k +: 32]));
      end
      result_count++;
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off
  initial out_tready = 1'b0;
  always @(negedge clk) begin
    if (holdoff_left != 0) begin
      out_tready   <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_tick(input tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= t;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tick(t);
  endtask

  // drop valid and wait until every predicted result has come out
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (torque_fifo.size() != 0) @(posedge clk);
  endtask

  // one APB transaction; reads are checked against the register image
  task automatic cfg_access(input bit do_write, input logic [2:0] idx, input word_t value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= do_write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx < NUM_REGS) begin
      if (do_write) gain_reg[idx] = value;
      else if (cfg_prdata !== gain_reg[idx])
        report_mismatch("register readback", cfg_prdata, gain_reg[idx]);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic tick_t make_tick(
    input logic [15:0] fwd, input logic [15:0] yaw,
    input logic [15:0] tgt1, input logic [15:0] tgt2,
    input logic [15:0] spd_l, input logic [15:0] spd_r,
    input logic [15:0] ang1, input logic [15:0] ang2);
    return {ang2, ang1, spd_r, spd_l, tgt2, tgt1, yaw, fwd};
  endfunction

  function automatic word_t pick_gain(input int idx);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return $urandom;
    if (r == 3) return CFG_RESET[idx];
    if (r == 4) return $urandom_range(255);
    return $urandom_range(32'h00FF_FFFF);
  endfunction

  function automatic tick_t rand_tick();
    logic [127:0] v;
    logic [15:0]  corner;
    int unsigned  r;
    int           f;
    r = $urandom_range(19);
    v = {$urandom, $urandom, $urandom, $urandom};
    if (r >= 12 && r <= 16) begin
      // small signals: errors stay modest and integrators build up
      for (f = 0; f < 8; f++) v[16*f +: 16] = 16'($urandom_range(1024)) - 16'd512;
    end else if (r == 17 || r == 18) begin
      // stopped base: commands zero
      v[31:0] = '0;
    end else if (r == 19) begin
      for (f = 0; f < 8; f++) begin
        case ($urandom_range(4))
          0: corner = 16'h8000;
          1: corner = 16'hFFFF;
          2: corner = 16'h0000;
          3: corner = 16'h0001;
          default: corner = 16'h7FFF;
        endcase
        v[16*f +: 16] = corner;
      end
    end
    return v;
  endfunction

  task automatic load_random_gains();
    int i;
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b1, 3'(i), pick_gain(i));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_access();
    int i;
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b0, 3'(i), '0);
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b1, 3'(i), $urandom);
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b0, 3'(i), '0);
    // write past the last register must not land anywhere
    cfg_access(1'b1, REG_UNUSED, $urandom);
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b0, 3'(i), '0);
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b1, 3'(i), CFG_RESET[i]);
  endtask

  task automatic test_directed_ticks();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(16'h7FFF, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(16'h8000, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 16'h7FFF, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 16'h8000, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 16'h7FFF, 16'h8000, 0, 0, 16'h8000, 16'h7FFF));
    // zero commands with moving wheels clear the wheel integrators
    send_tick(make_tick(0, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 0));
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_tick(make_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_tick(make_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000));
    settle();
  endtask

  task automatic test_saturation();
    int i;
    // maximum gains: wheel error, integrator and torque all clip
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b1, 3'(i), '1);
    for (i = 0; i < 3; i++)
      send_tick(make_tick(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                          16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
    for (i = 0; i < 3; i++)
      send_tick(make_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
    settle();
    // zero gains: targets always zero, all torques zero
    for (i = 0; i < NUM_REGS; i++) cfg_access(1'b1, 3'(i), '0);
    send_tick(make_tick(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                        16'h1234, 16'hEDCB, 16'h8000, 16'h7FFF));
    send_tick(make_tick(16'h8000, 16'h7FFF, 0, 0, 16'h7FFF, 16'h8000, 0, 0));
    settle();
  endtask

  task automatic test_floor_to_zero();
    // unit kinematic gains: small positive commands floor to zero
    cfg_access(1'b1, REG_INV_RADIUS, 32'd1);
    cfg_access(1'b1, REG_YAW_SCALE,  32'd1);
    cfg_access(1'b1, REG_WHEEL_KP,   32'h0001_0000);
    cfg_access(1'b1, REG_WHEEL_KI,   32'h0001_0000);
    cfg_access(1'b1, REG_ARM_KP,     32'h0001_0000);
    cfg_access(1'b1, REG_ARM_KI,     32'h0001_0000);
    cfg_access(1'b1, REG_ARM_KD,     32'h0001_0000);
    // targets -1: sums build, arm angle swings full range
    send_tick(make_tick(16'hFFFB, 0, 16'd100, 16'hFF00, 16'd300, 16'hFE00,
                        16'h7FFF, 16'h8000));
    send_tick(make_tick(16'hFFFB, 0, 16'd100, 16'hFF00, 16'd300, 16'hFE00,
                        16'h8000, 16'h7FFF));
    // only the left target is zero: no clear
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 0, 0, 16'd50, 16'd70, 0, 0));
    // nonzero commands flooring to zero on both sides: clear
    send_tick(make_tick(16'd3, 16'd7, 0, 0, 16'd50, 16'd70, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 16'd9, 16'hFFF0, 0, 0));
    settle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int n;
    load_random_gains();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (n = 0; n < count; n++) send_tick(rand_tick());
    settle();
  endtask

  task automatic test_output_holdoff();
    int n;
    load_random_gains();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = HOLDOFF_CYCLES;
    for (n = 0; n < 60; n++) send_tick(rand_tick());
    settle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int i;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    for (i = 0; i < NUM_REGS; i++) gain_reg[i] = CFG_RESET[i];
    for (i = 0; i < 2; i++) begin
      wheel_sum[i]  = '0;
      arm_sum[i]    = '0;
      prev_angle[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed_ticks();
    test_saturation();
    test_floor_to_zero();
    test_random_traffic(0, 0, 350);
    test_random_traffic(85, 0, 350);
    test_random_traffic(0, 85, 350);
    test_random_traffic(28, 28, 350);
    test_output_holdoff();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && torque_fifo.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ diff_drive_wheel_arm_pid.f @@
+incdir+sv
sv/ddwap_pkg.sv
sv/ddwap_kin.sv
sv/ddwap_lane.sv
sv/diff_drive_wheel_arm_pid.sv
tb/sv/tb_top.sv
